// ----- rtl/gradient_noise_2d_unit_macros.svh -----
// assertion macros for the gradient noise unit
`ifndef GRADIENT_NOISE_2D_UNIT_MACROS_SVH
`define GRADIENT_NOISE_2D_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define GN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gn check failed");
// next-cycle implication
`define GN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gn check failed");
`endif

// ----- rtl/gn2d_pkg.sv -----
// package with types, constants and fixed-point helpers for the gradient noise unit
`timescale 1ns / 1ps
package gn2d_pkg;
   localparam int TableSize    = 256;
   localparam int FracBits     = 16;
   localparam int IdxBits      = $clog2(TableSize);
   localparam int OutBits      = 19;
   localparam logic MODE_EVAL  = 1'b0;
   localparam logic MODE_LOAD  = 1'b1;

   typedef logic [IdxBits-1:0]       idx_type;
   typedef logic [7:0]               entry_type;
   typedef logic [FracBits-1:0]      frac_type;
   typedef logic signed [OutBits-1:0] noise_type;

   typedef struct packed {
      logic              mode;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [7:0]        entry_index;
      logic [7:0]        entry_value;
   } req_word_type;

   // gradient value: sign of dx chosen by bit 0, of dy by bit 1
   function automatic logic signed [FracBits+2:0] grad(input entry_type h,
         input logic signed [FracBits+1:0] dx, input logic signed [FracBits+1:0] dy);
      logic signed [FracBits+2:0] a;
      logic signed [FracBits+2:0] b;
      a = h[0] ? {dx[FracBits+1], dx} : -{dx[FracBits+1], dx};
      b = h[1] ? {dy[FracBits+1], dy} : -{dy[FracBits+1], dy};
      return a + b;
   endfunction
endpackage

// ----- rtl/gn2d_channel_if.sv -----
// valid/ready channel interface
`timescale 1ns / 1ps
interface gn2d_channel_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ----- rtl/gradient_noise_2d_unit.sv -----
// gradient noise 2d unit: pipelined perlin noise with loadable permutation table
//
// req channel carries a request word: mode, point_x, point_y (signed Q16.16),
// entry_index and entry_value. mode load writes one permutation entry and makes
// no response; mode eval returns one rsp word, noise_value, signed Q2.16.
// rsp valid and the rsp word come from the registers of the last pipeline stage.
// when rsp is not stalled, throughput is one word per cycle: every stage
// advances together, and the stages are set by the multiplier chain of the
// fade polynomial and the two lerp levels; the hash reads three copies of the
// table, two entries each.
// after reset a clearing pass writes entry i with i in every copy; req ready
// stays low until it ends. when rsp is stalled the whole pipe holds; req
// ready drops only during the clearing pass or while the output stage holds
// a word that is not taken. a load enters at the table on accept; later
// evaluations see it, earlier ones already read their hashes.
`timescale 1ns / 1ps
`include "gradient_noise_2d_unit_macros.svh"
module gradient_noise_2d_unit
   import gn2d_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   gn2d_channel_if.sink   req,
   gn2d_channel_if.source rsp
);
   localparam int S = 7;
   localparam logic signed [FracBits+1:0] ONE = (FracBits+2)'(1) <<< FracBits;

   req_word_type req_w;
   logic         adv;
   logic         req_take;
   logic [S-1:0] vld_ff;
   logic         clear_ff;
   idx_type      clear_idx_ff;
   logic         wr_en;
   idx_type      wr_addr;
   entry_type    wr_data;
   entry_type    perm_a_mem [TableSize];
   entry_type    perm_b_mem [TableSize];
   entry_type    perm_c_mem [TableSize];

   assign req_w     = req_word_type'(req.word);
   assign adv       = !vld_ff[S-1] || rsp.ready;
   assign req.ready = adv && !clear_ff;
   assign req_take  = req.valid && req.ready;

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_idx_ff <= '0;
      end else if (clear_ff) begin
         clear_idx_ff <= clear_idx_ff + idx_type'(1);
         if (clear_idx_ff == idx_type'(TableSize-1)) clear_ff <= 1'b0;
      end
   end

   always_comb begin
      wr_en   = clear_ff || (req_take && req_w.mode == MODE_LOAD);
      wr_addr = clear_ff ? clear_idx_ff : idx_type'(req_w.entry_index);
      wr_data = clear_ff ? entry_type'(clear_idx_ff) : req_w.entry_value;
   end

   // table writes, applied in request order to all copies
   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_a_mem[wr_addr] <= wr_data;
         perm_b_mem[wr_addr] <= wr_data;
         perm_c_mem[wr_addr] <= wr_data;
      end
   end

   // stage 1: split point, first hash level, t squared
   idx_type   yi1_ff;
   frac_type  xr1_ff, yr1_ff;
   entry_type px0_ff, px1_ff;
   logic [2*FracBits-1:0] tx2p_ff, ty2p_ff;
   // stage 2
   frac_type  xr2_ff, yr2_ff, tx2_2_ff, ty2_2_ff;
   entry_type h00_ff, h01_ff, h10_ff, h11_ff;
   logic [2*FracBits-1:0] tx3p_ff, ty3p_ff;
   // stage 3
   frac_type  tx3_ff, ty3_ff;
   logic signed [FracBits+4:0] polx_ff, poly_ff;
   logic signed [FracBits+2:0] g00_3_ff, g01_3_ff, g10_3_ff, g11_3_ff;
   // stage 4: fade product
   logic signed [2*FracBits+5:0] upr_ff, vpr_ff;
   logic signed [FracBits+2:0] g00_4_ff, g01_4_ff, g10_4_ff, g11_4_ff;
   // stage 5: lerp along x products
   logic signed [FracBits+4:0] v5_ff;
   logic signed [FracBits+2:0] g00_5_ff, g01_5_ff;
   logic signed [2*FracBits+8:0] p1_ff, p2_ff;
   // stage 6: lerp along y product
   logic signed [FracBits+4:0] m1_ff;
   logic signed [2*FracBits+10:0] p3_ff;
   // stage 7
   noise_type out_ff;

   logic signed [FracBits+4:0] u_in, v_in, m1_in, m2_in;
   logic signed [FracBits+6:0] m3_in;
   logic signed [FracBits+1:0] dx0, dx1, dy0, dy1;

   always_comb begin
      u_in  = (FracBits+5)'(upr_ff >>> FracBits);
      v_in  = (FracBits+5)'(vpr_ff >>> FracBits);
      m1_in = (FracBits+5)'(g00_5_ff) + (FracBits+5)'(p1_ff >>> FracBits);
      m2_in = (FracBits+5)'(g01_5_ff) + (FracBits+5)'(p2_ff >>> FracBits);
      m3_in = (FracBits+7)'(m1_ff) + (FracBits+7)'(p3_ff >>> FracBits);
      dx0 = (FracBits+2)'({2'b00, xr2_ff});
      dy0 = (FracBits+2)'({2'b00, yr2_ff});
      dx1 = dx0 - ONE;
      dy1 = dy0 - ONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[S-2:0], req_take && req_w.mode == MODE_EVAL};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         yi1_ff  <= idx_type'(req_w.point_y[FracBits +: IdxBits]);
         xr1_ff  <= req_w.point_x[FracBits-1:0];
         yr1_ff  <= req_w.point_y[FracBits-1:0];
         px0_ff  <= perm_a_mem[idx_type'(req_w.point_x[FracBits +: IdxBits])];
         px1_ff  <= perm_a_mem[idx_type'(req_w.point_x[FracBits +: IdxBits]) + idx_type'(1)];
         tx2p_ff <= req_w.point_x[FracBits-1:0] * req_w.point_x[FracBits-1:0];
         ty2p_ff <= req_w.point_y[FracBits-1:0] * req_w.point_y[FracBits-1:0];

         xr2_ff   <= xr1_ff;
         yr2_ff   <= yr1_ff;
         tx2_2_ff <= tx2p_ff[2*FracBits-1:FracBits];
         ty2_2_ff <= ty2p_ff[2*FracBits-1:FracBits];
         h00_ff <= perm_b_mem[idx_type'(px0_ff) + yi1_ff];
         h01_ff <= perm_b_mem[idx_type'(px0_ff) + yi1_ff + idx_type'(1)];
         h10_ff <= perm_c_mem[idx_type'(px1_ff) + yi1_ff];
         h11_ff <= perm_c_mem[idx_type'(px1_ff) + yi1_ff + idx_type'(1)];
         tx3p_ff <= tx2p_ff[2*FracBits-1:FracBits] * xr1_ff;
         ty3p_ff <= ty2p_ff[2*FracBits-1:FracBits] * yr1_ff;

         tx3_ff <= tx3p_ff[2*FracBits-1:FracBits];
         ty3_ff <= ty3p_ff[2*FracBits-1:FracBits];
         polx_ff <= (FracBits+5)'(6) * $signed({5'b0, tx2_2_ff})
                  - (FracBits+5)'(15) * $signed({5'b0, xr2_ff})
                  + ((FracBits+5)'(10) <<< FracBits);
         poly_ff <= (FracBits+5)'(6) * $signed({5'b0, ty2_2_ff})
                  - (FracBits+5)'(15) * $signed({5'b0, yr2_ff})
                  + ((FracBits+5)'(10) <<< FracBits);
         g00_3_ff <= grad(h00_ff, dx0, dy0);
         g01_3_ff <= grad(h01_ff, dx0, dy1);
         g10_3_ff <= grad(h10_ff, dx1, dy0);
         g11_3_ff <= grad(h11_ff, dx1, dy1);

         upr_ff <= (2*FracBits+6)'($signed({1'b0, tx3_ff}) * polx_ff);
         vpr_ff <= (2*FracBits+6)'($signed({1'b0, ty3_ff}) * poly_ff);
         g00_4_ff <= g00_3_ff;
         g01_4_ff <= g01_3_ff;
         g10_4_ff <= g10_3_ff;
         g11_4_ff <= g11_3_ff;

         v5_ff <= v_in;
         g00_5_ff <= g00_4_ff;
         g01_5_ff <= g01_4_ff;
         p1_ff <= (2*FracBits+9)'(u_in * ((FracBits+4)'(g10_4_ff) - (FracBits+4)'(g00_4_ff)));
         p2_ff <= (2*FracBits+9)'(u_in * ((FracBits+4)'(g11_4_ff) - (FracBits+4)'(g01_4_ff)));

         m1_ff <= m1_in;
         p3_ff <= (2*FracBits+11)'(v5_ff * ((FracBits+6)'(m2_in) - (FracBits+6)'(m1_in)));

         if (m3_in > (FracBits+7)'(262143))       out_ff <= noise_type'(262143);
         else if (m3_in < -(FracBits+7)'(262144)) out_ff <= noise_type'(-262144);
         else                                     out_ff <= noise_type'(m3_in);
      end
   end

   assign rsp.valid = vld_ff[S-1];
   assign rsp.word  = out_ff;

   `GN_ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.word))
   `GN_ASSERT_IMP(a_ready_when_free, clock, reset, !rsp.valid && !clear_ff, req.ready)
   `GN_ASSERT_NEXT(a_load_no_rsp, clock, reset,
      req.valid && req.ready && req_w.mode == MODE_LOAD, !vld_ff[0])
   `GN_ASSERT_NEXT(a_eval_enters, clock, reset,
      req.valid && req.ready && req_w.mode == MODE_EVAL, vld_ff[0])
endmodule

// ----- tb/gn2d_scoreboard.sv -----
// scoreboard for the gradient noise unit: table copy, noise predictor and result check
`timescale 1ns / 1ps
package gn2d_tb_pkg;
   import gn2d_pkg::*;

   class noise_scoreboard;
      entry_type perm [TableSize];
      longint noise_queue [$];
      int errors;

      function new();
         errors = 0;
         for (int i = 0; i < TableSize; i++) perm[i] = entry_type'(i);
      endfunction

      static function longint fl_shift(longint p);
         return p >>> FracBits;
      endfunction

      static function longint fade(longint t);
         longint t2, t3, poly;
         t2 = fl_shift(t * t);
         t3 = fl_shift(t2 * t);
         poly = 6 * t2 - 15 * t + 10 * (longint'(1) << FracBits);
         return fl_shift(t3 * poly);
      endfunction

      static function longint blend(longint w, longint a, longint b);
         return a + fl_shift(w * (b - a));
      endfunction

      static function longint slope(entry_type h, longint dx, longint dy);
         return (h[0] ? dx : -dx) + (h[1] ? dy : -dy);
      endfunction

      function entry_type hash_at(longint idx);
         return perm[idx % TableSize];
      endfunction

      function longint noise_at(req_word_type w);
         longint one, x, y, xi, yi, xr, yr, u, v, m1, m2, m3;
         entry_type px0, px1, h00, h01, h10, h11;
         one = longint'(1) << FracBits;
         x = longint'(w.point_x);
         y = longint'(w.point_y);
         xr = x & (one - 1);
         yr = y & (one - 1);
         xi = fl_shift(x) & (TableSize - 1);
         yi = fl_shift(y) & (TableSize - 1);
         u = fade(xr);
         v = fade(yr);
         px0 = hash_at(xi);
         px1 = hash_at(xi + 1);
         h00 = hash_at(px0 + yi);
         h01 = hash_at(px0 + yi + 1);
         h10 = hash_at(px1 + yi);
         h11 = hash_at(px1 + yi + 1);
         m1 = blend(u, slope(h00, xr, yr), slope(h10, xr - one, yr));
         m2 = blend(u, slope(h01, xr, yr - one), slope(h11, xr - one, yr - one));
         m3 = blend(v, m1, m2);
         if (m3 > 262143) m3 = 262143;
         if (m3 < -262144) m3 = -262144;
         return m3;
      endfunction

      function void note_request(req_word_type w);
         if (w.mode == MODE_LOAD) begin
            perm[w.entry_index % TableSize] = w.entry_value;
         end else begin
            noise_queue.push_back(noise_at(w));
         end
      endfunction

      function void check_noise(noise_type got);
         noise_type want;
         if (noise_queue.size() == 0) begin
            $error("noise_value: unexpected word, actual %0d", got);
            errors++;
         end else begin
            want = noise_type'(noise_queue.pop_front());
            if (want !== got) begin
               $error("noise_value: expected %0d, actual %0d", want, got);
               errors++;
            end
         end
      endfunction
   endclass
endpackage

// ----- tb/testbench.sv -----
// testbench top: drives requests, stalls responses and checks noise values
`timescale 1ns / 1ps
module testbench;
   import gn2d_pkg::*;
   import gn2d_tb_pkg::*;

   localparam int CycleLimit = 400000;

   logic clock;
   logic reset;
   int cycles = 0;
   bit rsp_hold;
   bit calm;
   noise_scoreboard board;

   gn2d_channel_if #(.WIDTH($bits(req_word_type))) req ();
   gn2d_channel_if #(.WIDTH(OutBits)) rsp ();

   gradient_noise_2d_unit dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rand_coord(int style);
      case (style)
         0: return $urandom();
         1: return {$urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom_range(0, 600)),
               16'($urandom())};
         default: return {16'($urandom()), 16'($urandom_range(0, 3) * 16'h4000)};
      endcase
   endfunction

   task automatic send_word(req_word_type w);
      while (!calm && $urandom_range(0, 99) < 19) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.word <= w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_eval(logic [31:0] x, logic [31:0] y);
      req_word_type w;
      w = '0;
      w.mode = MODE_EVAL;
      w.point_x = x;
      w.point_y = y;
      w.entry_index = 8'($urandom());
      w.entry_value = 8'($urandom());
      send_word(w);
   endtask

   task automatic send_load(logic [7:0] idx, logic [7:0] val);
      req_word_type w;
      w = '0;
      w.mode = MODE_LOAD;
      w.point_x = $urandom();
      w.point_y = $urandom();
      w.entry_index = idx;
      w.entry_value = val;
      send_word(w);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      @(negedge clock);
      while (board.noise_queue.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) board.note_request(req_word_type'(req.word));
         if (rsp.valid && rsp.ready) board.check_noise(noise_type'(rsp.word));
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= !rsp_hold && (calm || $urandom_range(0, 99) >= 19);
      end
   end

   initial begin
      board = new();
      calm = 1'b0;
      rsp_hold = 1'b0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.word = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_eval(32'h0, 32'h0);
      send_eval(32'h7fffffff, 32'h7fffffff);
      send_eval(32'h80000000, 32'h80000000);
      send_eval(32'hffffffff, 32'h00000001);
      send_eval(32'h00008000, 32'hffff8000);
      send_eval(32'h00ff0000, 32'h00ffffff);
      send_eval(32'h00ffffff, 32'hff00ffff);
      send_load(8'd0, 8'd255);
      send_load(8'd255, 8'd0);
      send_load(8'd1, 8'd200);
      send_eval(32'h00ff4000, 32'h00ffc000);
      send_eval(32'h0000c000, 32'h00014000);
      send_eval(32'h5555aaaa, 32'haaaa5555);
      for (int i = 0; i < 256; i++) send_load(8'(i), 8'($urandom()));
      wait_drained();

      for (int n = 0; n < 530; n++) begin
         if (n == 150) begin
            calm = 1'b1;
         end
         if (n == 300) begin
            calm = 1'b0;
            fork
               begin
                  rsp_hold = 1'b1;
                  repeat (60) @(negedge clock);
                  rsp_hold = 1'b0;
               end
            join_none
         end
         if (n == 450) wait_drained();
         if ($urandom_range(0, 9) == 0) begin
            send_load(8'($urandom()), 8'($urandom()));
         end else begin
            send_eval(rand_coord($urandom_range(0, 2)), rand_coord($urandom_range(0, 2)));
         end
      end
      wait_drained();
      repeat (30) @(posedge clock);
      if (board.errors == 0 && board.noise_queue.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
